FILE: rtl/base64_stream_encoder_defines.svh
// Assertion macros used by the encoder's job queue.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/b64e_pkg.sv
// Types, constants and the alphabet function for the Base64 encoder.
package b64e_pkg;

    localparam int unsigned B64E_QUEUE_DEPTH = 4;
    localparam logic [7:0]  PAD_CHAR         = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       message_end;
        logic       run_last;
    } t_out_word;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // One decoded item: up to three characters for the back end.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            char_valid;
        logic            is_end;
    } t_job;

    // A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_sym(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (v < 8'd26) begin
            return 8'h41 + v;
        end else if (v < 8'd52) begin
            return 8'h61 + (v - 8'd26);
        end else if (v < 8'd62) begin
            return 8'h30 + (v - 8'd52);
        end else if (v == 8'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

FILE: rtl/base64_stream_encoder.sv
// Streaming Base64 encoder top level: front end, job queue and character back end.
//
// Encodes a byte stream into padded Base64 (A-Z a-z 0-9 + /, '=' pad), one
// input word per byte plus an end-marker word that flushes and pads the
// message. The front end takes one input word per cycle while the job queue
// (QUEUE_DEPTH entries, 2 or more) has room; the back end writes one character
// per cycle into the output register unless the output is stalled. A byte
// gives one character, a byte that closes a group of three gives two, and an
// end marker gives one to three (an empty end word when no bits are left
// over), each word flagged run_last on the last character of its item.
// Sustained rate is set by that single character per cycle at the output,
// with bursts of up to QUEUE_DEPTH items absorbed while the output is stalled.
// Accepted words pass through the job queue into the output register.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic push, pop, full, q_valid;
    t_job front_job, head_job;

    // classify the word, advance phase/carry, build the character job
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_job   (front_job)
    );

    // decouples input acceptance from output stalls
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // one character word per cycle while the output is not stalled
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word),
        .i_stall     (i_out_stall)
    );

endmodule

FILE: rtl/b64e_front.sv
// Front end: takes input words, tracks group phase and leftover bits, builds jobs.
module b64e_front
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_full,
    output logic     o_stall,
    output logic     o_push,
    output t_job     o_job
);

    t_phase     r_phase, n_phase;
    logic [5:0] r_carry, n_carry;
    logic       accept;
    logic [7:0] b;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign b       = i_word.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= 6'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

    always_comb begin
        n_phase          = PH_0;
        n_carry          = 6'd0;
        o_job.chars      = '0;
        o_job.last_idx   = 2'd0;
        o_job.char_valid = 1'b1;
        o_job.is_end     = i_word.end_marker;
        if (i_word.end_marker) begin
            case (r_phase)
                PH_1: begin
                    o_job.chars[0] = b64_sym(r_carry);
                    o_job.chars[1] = PAD_CHAR;
                    o_job.chars[2] = PAD_CHAR;
                    o_job.last_idx = 2'd2;
                end
                PH_2: begin
                    o_job.chars[0] = b64_sym(r_carry);
                    o_job.chars[1] = PAD_CHAR;
                    o_job.last_idx = 2'd1;
                end
                default: begin
                    // nothing left over: one empty end word
                    o_job.char_valid = 1'b0;
                end
            endcase
        end else begin
            case (r_phase)
                PH_1: begin
                    o_job.chars[0] = b64_sym(r_carry | {2'b00, b[7:4]});
                    n_carry        = {b[3:0], 2'b00};
                    n_phase        = PH_2;
                end
                PH_2: begin
                    o_job.chars[0] = b64_sym(r_carry | {4'b0000, b[7:6]});
                    o_job.chars[1] = b64_sym(b[5:0]);
                    o_job.last_idx = 2'd1;
                end
                default: begin
                    o_job.chars[0] = b64_sym(b[7:2]);
                    n_carry        = {b[1:0], 4'b0000};
                    n_phase        = PH_1;
                end
            endcase
        end
    end

endmodule

FILE: rtl/b64e_queue.sv
// Small job FIFO between the front and back ends.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

`include "base64_stream_encoder_defines.svh"

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `B64E_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "queue overfill")
    `B64E_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into full queue")
    `B64E_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `B64E_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + 1'b1, "count did not rise on push")

endmodule

FILE: rtl/b64e_back.sv
// Back end: one character per unstalled cycle from the head job into the output register.
module b64e_back
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_stall
);

    logic [1:0] r_sub;
    logic       r_valid;
    t_out_word  r_word;
    logic       load, emit, last;

    assign load   = !r_valid || !i_stall;
    assign emit   = load && i_job_valid;
    assign last   = (r_sub == i_job.last_idx);
    assign o_pop  = emit && last;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (emit) begin
                r_sub <= last ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word.out_char    <= i_job.chars[r_sub];
            r_word.char_valid  <= i_job.char_valid;
            r_word.message_end <= i_job.is_end && last;
            r_word.run_last    <= last;
        end
    end

endmodule

FILE: test/tb.sv
// Self-checking testbench for the streaming Base64 encoder.
module tb;
    import b64e_pkg::*;

    // Tracks the encoder's group state and holds the characters still owed.
    class b64_scoreboard;
        t_out_word  pending_chars[$];
        t_phase     phase;
        logic [5:0] carry;
        int         mismatches;
        string      alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            phase      = PH_0;
            carry      = '0;
            mismatches = 0;
        endfunction

        function logic [7:0] sym(input logic [5:0] idx);
            return alphabet[idx];
        endfunction

        function void push_char(input logic [7:0] ch, input logic valid,
                                input logic mend, input logic last);
            t_out_word w;
            w.out_char    = ch;
            w.char_valid  = valid;
            w.message_end = mend;
            w.run_last    = last;
            pending_chars.push_back(w);
        endfunction

        // Called once per accepted input word.
        function void note_word(input t_in_word w);
            if (w.end_marker) begin
                case (phase)
                    PH_1: begin
                        push_char(sym(carry), 1'b1, 1'b0, 1'b0);
                        push_char(PAD_CHAR, 1'b1, 1'b0, 1'b0);
                        push_char(PAD_CHAR, 1'b1, 1'b1, 1'b1);
                    end
                    PH_2: begin
                        push_char(sym(carry), 1'b1, 1'b0, 1'b0);
                        push_char(PAD_CHAR, 1'b1, 1'b1, 1'b1);
                    end
                    // nothing left over: one empty end word
                    default: push_char(8'h00, 1'b0, 1'b1, 1'b1);
                endcase
                phase = PH_0;
                carry = '0;
            end else begin
                case (phase)
                    PH_1: begin
                        push_char(sym(carry | {2'b00, w.data_byte[7:4]}), 1'b1, 1'b0, 1'b1);
                        carry = {w.data_byte[3:0], 2'b00};
                        phase = PH_2;
                    end
                    PH_2: begin
                        push_char(sym(carry | {4'b0000, w.data_byte[7:6]}), 1'b1, 1'b0, 1'b0);
                        push_char(sym(w.data_byte[5:0]), 1'b1, 1'b0, 1'b1);
                        carry = '0;
                        phase = PH_0;
                    end
                    default: begin
                        push_char(sym(w.data_byte[7:2]), 1'b1, 1'b0, 1'b1);
                        carry = {w.data_byte[1:0], 4'b0000};
                        phase = PH_1;
                    end
                endcase
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 50) begin
                $display("%0t: %s", $time, msg);
            end
        endtask

        // Called once per accepted output word.
        task check_word(input t_out_word got);
            t_out_word want;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = pending_chars.pop_front();
                if (got.out_char !== want.out_char)
                    report_mismatch($sformatf("out_char got %h want %h",
                                              got.out_char, want.out_char));
                if (got.char_valid !== want.char_valid)
                    report_mismatch($sformatf("char_valid got %b want %b",
                                              got.char_valid, want.char_valid));
                if (got.message_end !== want.message_end)
                    report_mismatch($sformatf("message_end got %b want %b",
                                              got.message_end, want.message_end));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last got %b want %b",
                                              got.run_last, want.run_last));
            end
        endtask

        task drain_check();
            if (pending_chars.size() != 0)
                report_mismatch($sformatf("%0d expected words never arrived",
                                          pending_chars.size()));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    b64_scoreboard sb;
    bit            no_idle     = 1'b0;  // both sides run without gaps while set
    int            hold_cycles = 0;     // one-shot long stall request for the receiver
    int            words_sent  = 0;

    base64_stream_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Offer one word after a random gap and hold it until the encoder takes it.
    // With a zero gap valid simply stays high from the previous word.
    task automatic send_word(input logic [7:0] data, input logic eom);
        int       gap;
        t_in_word w;
        gap          = no_idle ? 0 : $urandom_range(0, 5);
        w.data_byte  = data;
        w.end_marker = eom;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        words_sent++;
    endtask

    // Random message body; an unterminated one runs straight into the next.
    task automatic send_message(input int len, input bit terminated);
        int i;
        for (i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), 1'b0);
        if (terminated)
            send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Sender goes quiet until every owed character has come out.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Receiver: random stall before each word, a long hold when requested.
    // out_stall is low while waiting, so any edge with valid high is a transfer.
    initial begin
        int stall_len;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                stall_len   = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall_len = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_word(out_word);
        end
    end

    initial begin
        int len;
        int start;
        int drain_wait;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // End right after reset: empty remainder, data byte must be ignored.
        send_word(8'hFF, 1'b1);
        // One byte left over: carry char plus two pads.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        // Two bytes left over: carry char plus one pad.
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        // Full groups of all ones and all zeros, then end on a group boundary.
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hA5, 1'b1);
        // Classic text group, then a group that maps to four '+' chars.
        send_word(8'h4D, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h6E, 1'b0);
        send_word(8'hFB, 1'b0);
        send_word(8'hEF, 1'b0);
        send_word(8'hBE, 1'b0);
        send_word(8'h5A, 1'b1);

        pause_until_drained();

        // Receiver holds off for a long stretch while the sender keeps
        // pushing back to back, so the job queue fills and input stalls.
        hold_cycles = 60;
        no_idle     = 1'b1;
        send_message(15, 1'b1);
        no_idle     = 1'b0;

        // Random part: mostly terminated messages of random length, some
        // empty, some left open so the next one starts mid-group.
        start = words_sent;
        while (words_sent - start < 160) begin
            if ($urandom_range(0, 7) == 0)
                no_idle = !no_idle;
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            send_message(len, $urandom_range(0, 7) != 0);
        end
        send_word(8'h00, 1'b1);

        // Let the tail drain, then keep waiting to catch stray words.
        in_valid   <= 1'b0;
        no_idle     = 1'b0;
        drain_wait  = 0;
        while (sb.pending_chars.size() != 0 && drain_wait < 2000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);
        sb.drain_check();
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: base64_stream_encoder.f
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
test/tb.sv
